// ----- rtl/core/pft_pkg.sv -----
// Package with widths and shared types for the prime factorizer.
package pft_pkg;
   localparam int NUM_WIDTH = 32;
   localparam int CNT_WIDTH = $clog2(NUM_WIDTH + 1);
   typedef logic [NUM_WIDTH-1:0] num_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
   } div_ctl_type;
endpackage

// ----- rtl/core/pft_divider.sv -----
// Restoring divider that produces one quotient bit per cycle.
module pft_divider (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  pft_pkg::num_type dividend,
   input  pft_pkg::num_type divisor,
   output pft_pkg::div_ctl_type ctl,
   output pft_pkg::num_type quotient,
   output pft_pkg::num_type remainder
);
   pft_pkg::num_type quo_ff, quo_in, rem_ff, rem_in, dsr_ff, dsr_in;
   logic [pft_pkg::CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic busy_ff, busy_in, done_ff, done_in;
   logic [pft_pkg::NUM_WIDTH:0] trial;
   logic [pft_pkg::NUM_WIDTH:0] shifted;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[pft_pkg::NUM_WIDTH-1]};
      trial   = shifted - {1'b0, dsr_ff};
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = pft_pkg::CNT_WIDTH'(pft_pkg::NUM_WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[pft_pkg::NUM_WIDTH]) begin
            rem_in = trial[pft_pkg::NUM_WIDTH-1:0];
            quo_in = {quo_ff[pft_pkg::NUM_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[pft_pkg::NUM_WIDTH-1:0];
            quo_in = {quo_ff[pft_pkg::NUM_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == pft_pkg::CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign ctl       = '{start: start, busy: busy_ff, done: done_ff};
   assign quotient  = quo_ff;
   assign remainder = rem_ff;
endmodule

// ----- rtl/core/prime_factorizer_totient.sv -----
// Top level: trial-division factorizer with Euler totient on a shared divider.
// Each trial divisor costs one divide on the shared divider.
// A 32-bit prime needs about 65536 trials.
// Inputs 0 and 1 skip the divider and go straight to EMIT; one item is in work at a time.
// Reset is synchronous and active high; it returns the sequencer to idle.
module prime_factorizer_totient (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // number
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // totient (upper), factor (lower)
   output logic        rsp_tlast    // last
);
   typedef enum logic [2:0] {
      IDLE, TRY, TRY_WAIT, PHI_DIV, PHI_WAIT, N_DIV, N_WAIT, EMIT
   } state_type;

   state_type state_ff, state_in;
   pft_pkg::num_type n_ff, n_in, d_ff, d_in, phi_ff, phi_in, prev_ff, prev_in;
   pft_pkg::num_type fac_ff, fac_in, tot_ff, tot_in;
   logic last_ff, last_in, vld_ff, vld_in;
   logic start;
   pft_pkg::num_type dvd, dsr, quo, rem;
   pft_pkg::div_ctl_type ctl;
   logic [pft_pkg::NUM_WIDTH:0] d_next;

   pft_divider u_div (
      .clock(clock), .reset(reset), .start(start), .dividend(dvd), .divisor(dsr),
      .ctl(ctl), .quotient(quo), .remainder(rem)
   );

   always_comb begin
      state_in = state_ff;
      n_in = n_ff; d_in = d_ff; phi_in = phi_ff; prev_in = prev_ff;
      fac_in = fac_ff; tot_in = tot_ff; last_in = last_ff; vld_in = vld_ff;
      start = 1'b0;
      dvd = n_ff;
      dsr = d_ff;
      d_next = {1'b0, d_ff} + 1'b1;
      if (vld_ff && rsp_tready) vld_in = 1'b0;
      unique case (state_ff)
         IDLE: begin
            if (req_tvalid) begin
               n_in = req_tdata; phi_in = req_tdata; d_in = 32'd2; prev_in = '0;
               if (req_tdata == 32'd0 || req_tdata == 32'd1) begin
                  fac_in = req_tdata; tot_in = req_tdata; last_in = 1'b1;
                  state_in = EMIT;
               end else begin
                  state_in = TRY;
               end
            end
         end
         TRY: begin
            start = 1'b1;
            state_in = TRY_WAIT;
         end
         TRY_WAIT: begin
            if (ctl.done) begin
               if (quo < d_ff) begin
                  d_in = n_ff;
                  state_in = PHI_DIV;
               end else if (rem == '0) begin
                  state_in = PHI_DIV;
               end else begin
                  d_in = d_next[pft_pkg::NUM_WIDTH-1:0];
                  state_in = TRY;
               end
            end
         end
         PHI_DIV: begin
            if (d_ff != prev_ff) begin
               dvd = phi_ff;
               start = 1'b1;
               state_in = PHI_WAIT;
            end else begin
               state_in = N_DIV;
            end
         end
         PHI_WAIT: begin
            if (ctl.done) begin
               phi_in = pft_pkg::num_type'(quo * (d_ff - 1'b1));
               state_in = N_DIV;
            end
         end
         N_DIV: begin
            start = 1'b1;
            state_in = N_WAIT;
         end
         N_WAIT: begin
            if (ctl.done) begin
               n_in = quo;
               prev_in = d_ff;
               fac_in = d_ff;
               last_in = (quo == 32'd1);
               tot_in = (quo == 32'd1) ? phi_ff : '0;
               state_in = EMIT;
            end
         end
         EMIT: begin
            if (!vld_ff || rsp_tready) begin
               vld_in = 1'b1;
               state_in = last_ff ? IDLE : TRY;
            end
         end
         default: state_in = IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= IDLE;
         vld_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         vld_ff <= vld_in;
      end
      n_ff <= n_in; d_ff <= d_in; phi_ff <= phi_in; prev_ff <= prev_in;
      fac_ff <= fac_in; tot_ff <= tot_in; last_ff <= last_in;
   end

   logic [31:0] out_fac, out_tot;
   logic out_last;
   always_ff @(posedge clock) begin
      if (state_ff == EMIT && (!vld_ff || rsp_tready)) begin
         out_fac <= fac_ff;
         out_tot <= tot_ff;
         out_last <= last_ff;
      end
   end

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata = {out_tot, out_fac};
   assign rsp_tlast = out_last;
endmodule
